@@ rtl/pmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pmr_pkg;

  // field widths
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned HEAD_W   = 16;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned POSE_W   = 2 * POS_W + HEAD_W;

  // saturation point of the prefix sum
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // particle count after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // search start from the controller
  typedef struct packed {
    logic                start;
    logic [WEIGHT_W-1:0] value;
    logic [CNT_W-1:0]    last;
  } search_req_t;

  // search completion back to the controller
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] index;
  } search_rsp_t;

endpackage

`default_nettype wire

@@ rtl/pmr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pmr_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pmr_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pmr_search #(
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pmr_pkg::search_req_t         req_i,
  output pmr_pkg::search_rsp_t              rsp_o,
  output logic                              cw_re_o,
  output logic [ADDR_W-1:0]                 cw_raddr_o,
  input  wire logic [pmr_pkg::SUM_W-1:0]    cw_rdata_i
);

  import pmr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_MID
  } state_e;

  state_e              state_q;
  logic [WEIGHT_W-1:0] r_q;
  logic [CNT_W-1:0]    lo_q;
  logic [CNT_W-1:0]    hi_q;
  logic [CNT_W-1:0]    mid_q;
  logic                done_q;
  logic [CNT_W-1:0]    index_q;

  logic [SUM_W-1:0]    r_ext;
  logic                below;
  logic                above;
  logic [CNT_W-1:0]    cur_span;
  logic [CNT_W-1:0]    cur_mid;
  logic [CNT_W-1:0]    nlo;
  logic [CNT_W-1:0]    nhi;
  logic [CNT_W-1:0]    nspan;
  logic [CNT_W-1:0]    nmid;

  // compares against the word read last cycle and the next bisection bounds
  always_comb begin
    r_ext    = SUM_W'(r_q);
    below    = r_ext < cw_rdata_i;
    above    = r_ext > cw_rdata_i;
    cur_span = hi_q - lo_q;
    cur_mid  = CNT_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
    if (cw_rdata_i < r_ext) begin
      nlo = mid_q;
      nhi = hi_q;
    end else begin
      nlo = lo_q;
      nhi = mid_q;
    end
    nspan = nhi - nlo;
    nmid  = CNT_W'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
  end

  // read address of the cumulative weight memory
  always_comb begin
    cw_re_o    = 1'b0;
    cw_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cw_re_o = req_i.start;
      end
      S_FIRST: begin
        cw_re_o    = !below;
        cw_raddr_o = ADDR_W'(hi_q);
      end
      S_LAST: begin
        cw_re_o    = !above && (cur_span > CNT_W'(1));
        cw_raddr_o = ADDR_W'(cur_mid);
      end
      S_MID: begin
        cw_re_o    = nspan > CNT_W'(1);
        cw_raddr_o = ADDR_W'(nmid);
      end
      default: begin
        cw_re_o = 1'b0;
      end
    endcase
  end

  // bisection sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      r_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      index_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            r_q     <= req_i.value;
            lo_q    <= '0;
            hi_q    <= req_i.last;
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (below) begin
            done_q  <= 1'b1;
            index_q <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          if (!above && (cur_span > CNT_W'(1))) begin
            mid_q   <= cur_mid;
            state_q <= S_MID;
          end else begin
            done_q  <= 1'b1;
            index_q <= hi_q;
            state_q <= S_IDLE;
          end
        end
        S_MID: begin
          lo_q <= nlo;
          hi_q <= nhi;
          if (nspan > CNT_W'(1)) begin
            mid_q <= nmid;
          end else begin
            done_q  <= 1'b1;
            index_q <= nhi;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.index = index_q;

endmodule

`default_nettype wire

@@ rtl/particle_multinomial_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Multinomial resampler for a particle filter.
// Input channel (in_valid_i/in_ready_o) carries one item per handshake:
// a load item (operation 0) stores a particle pose and adds its weight to a
// saturating prefix sum; start_of_set restarts the set at index 0.
// A draw item (operation 1) picks a particle by bisection over the stored
// cumulative weights and returns its index and pose on the output channel
// (out_valid_o/out_ready_i); every particle_count-th draw is marked last.
// A draw before a full set is loaded returns not_loaded with zero fields.
// A load gives no result. A draw runs a bisection search that issues one
// read of the cumulative weight memory per cycle, then reads the pose;
// the next item is taken once the result is in the output register. An
// early draw skips the search.
// The input is taken only between items; a finished result sits in the
// output register, so the next item is taken while the receiver stalls, and
// a following draw waits in its last step until that register is free.
// A write at a location is visible to a read from the next cycle on.
// Reset clears the counters, the prefix sum and the output valid, and sets
// particle_count to 1024; memory contents are kept as they are.

module particle_multinomial_resampler #(
  parameter int unsigned MAX_PARTICLES = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pmr_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            operation_i,
  input  wire logic                            start_of_set_i,
  input  wire logic signed [pmr_pkg::POS_W-1:0]  pos_x_i,
  input  wire logic signed [pmr_pkg::POS_W-1:0]  pos_y_i,
  input  wire logic signed [pmr_pkg::HEAD_W-1:0] heading_i,
  input  wire logic [pmr_pkg::WEIGHT_W-1:0]    particle_weight_i,
  input  wire logic [pmr_pkg::WEIGHT_W-1:0]    random_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [pmr_pkg::INDEX_W-1:0]          picked_index_o,
  output logic signed [pmr_pkg::POS_W-1:0]     out_x_o,
  output logic signed [pmr_pkg::POS_W-1:0]     out_y_o,
  output logic signed [pmr_pkg::HEAD_W-1:0]    out_heading_o,
  output logic                                 last_of_set_o,
  output logic                                 not_loaded_o
);

  import pmr_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_PARTICLES);
  localparam int unsigned CAP_INT = (MAX_PARTICLES < 2047) ? MAX_PARTICLES : 2047;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_POSE,
    ST_FLAG
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] particle_count_q;
  logic [CNT_W-1:0] load_count_q;
  logic [SUM_W-1:0] running_sum_q;
  logic [CNT_W-1:0] draw_count_q;
  logic [CNT_W-1:0] idx_q;
  logic             last_q;
  logic             out_valid_q;

  logic [CNT_W-1:0]  n_eff;
  logic              in_fire;
  logic              loaded;
  logic              slot_free;
  logic              out_load;
  logic [CNT_W-1:0]  base_count;
  logic [SUM_W-1:0]  base_sum;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  new_sum;
  logic              load_we;
  logic              draw_last;
  logic [CNT_W:0]    draw_next;

  search_req_t       search_req;
  search_rsp_t       search_rsp;
  logic              cw_re;
  logic [AW-1:0]     cw_raddr;
  logic [SUM_W-1:0]  cw_rdata;
  logic [POSE_W-1:0] pose_rdata;

  // effective particle count: zero acts as one, capped by the store depth
  always_comb begin
    if (particle_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (particle_count_q > CAP) begin
      n_eff = CAP;
    end else begin
      n_eff = particle_count_q;
    end
  end

  // handshake and load arithmetic
  always_comb begin
    in_ready_o = state_q == ST_IDLE;
    in_fire    = in_valid_i && in_ready_o;
    loaded     = load_count_q >= n_eff;
    slot_free  = !out_valid_q || out_ready_i;
    out_load   = ((state_q == ST_POSE) || (state_q == ST_FLAG)) && slot_free;
    base_count = start_of_set_i ? '0 : load_count_q;
    base_sum   = start_of_set_i ? '0 : running_sum_q;
    sum_wide   = {1'b0, base_sum} + (SUM_W + 1)'(particle_weight_i);
    new_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    load_we    = in_fire && (operation_i == OP_LOAD) && (base_count < n_eff);
    draw_next  = {1'b0, draw_count_q} + (CNT_W + 1)'(1);
    draw_last  = draw_next >= {1'b0, n_eff};
  end

  // search request
  always_comb begin
    search_req.start = in_fire && (operation_i == OP_DRAW) && loaded;
    search_req.value = random_value_i;
    search_req.last  = n_eff - CNT_W'(1);
  end

  pmr_search #(
    .ADDR_W (AW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (search_req),
    .rsp_o      (search_rsp),
    .cw_re_o    (cw_re),
    .cw_raddr_o (cw_raddr),
    .cw_rdata_i (cw_rdata)
  );

  // cumulative weights
  pmr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PARTICLES)
  ) u_cw_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(base_count)),
    .wdata_i (new_sum),
    .re_i    (cw_re),
    .raddr_i (cw_raddr),
    .rdata_o (cw_rdata)
  );

  // poses, packed as x, y, heading
  pmr_ram #(
    .WIDTH (POSE_W),
    .DEPTH (MAX_PARTICLES)
  ) u_pose_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(base_count)),
    .wdata_i ({pos_x_i, pos_y_i, heading_i}),
    .re_i    (search_rsp.done),
    .raddr_i (AW'(search_rsp.index)),
    .rdata_o (pose_rdata)
  );

  // control, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      particle_count_q <= COUNT_RESET;
      load_count_q     <= '0;
      running_sum_q    <= '0;
      draw_count_q     <= '0;
      idx_q            <= '0;
      last_q           <= 1'b0;
      out_valid_q      <= 1'b0;
      picked_index_o   <= '0;
      out_x_o          <= '0;
      out_y_o          <= '0;
      out_heading_o    <= '0;
      last_of_set_o    <= 1'b0;
      not_loaded_o     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        particle_count_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (operation_i == OP_LOAD) begin
              // a start of set always writes slot 0, so load_we covers the restart
              if (start_of_set_i) begin
                draw_count_q <= '0;
              end
              if (load_we) begin
                running_sum_q <= new_sum;
                load_count_q  <= base_count + CNT_W'(1);
              end
            end else if (loaded) begin
              last_q       <= draw_last;
              draw_count_q <= draw_last ? '0 : draw_next[CNT_W-1:0];
              state_q      <= ST_SEARCH;
            end else begin
              state_q <= ST_FLAG;
            end
          end
        end
        ST_SEARCH: begin
          if (search_rsp.done) begin
            idx_q   <= search_rsp.index;
            state_q <= ST_POSE;
          end
        end
        ST_POSE: begin
          if (slot_free) begin
            out_valid_q    <= 1'b1;
            picked_index_o <= INDEX_W'(idx_q);
            out_x_o        <= pose_rdata[POSE_W-1 -: POS_W];
            out_y_o        <= pose_rdata[HEAD_W +: POS_W];
            out_heading_o  <= pose_rdata[HEAD_W-1:0];
            last_of_set_o  <= last_q;
            not_loaded_o   <= 1'b0;
            state_q        <= ST_IDLE;
          end
        end
        ST_FLAG: begin
          if (slot_free) begin
            out_valid_q    <= 1'b1;
            picked_index_o <= '0;
            out_x_o        <= '0;
            out_y_o        <= '0;
            out_heading_o  <= '0;
            last_of_set_o  <= 1'b0;
            not_loaded_o   <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // search completes only while the controller waits for it
  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    search_rsp.done |-> state_q == ST_SEARCH)
    else $error("search done outside search state");

  // memory writes only happen between draws
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we |-> (state_q == ST_IDLE && !cw_re))
    else $error("load write during a draw");

  // the picked particle lies inside the active set
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POSE) |-> idx_q < n_eff)
    else $error("picked index beyond particle count");

  // an early draw carries no pick
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && not_loaded_o) |-> (picked_index_o == '0 && !last_of_set_o))
    else $error("not_loaded result with nonzero fields");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pmr_pkg::*;

  localparam int unsigned MAX_PARTS     = 1024;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam longint unsigned TIMEOUT_NS = 64'd8_000_000;

  localparam logic [WEIGHT_W-1:0]      WEIGHT_ONE = 17'h10000;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX   = 16'sd25736;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN   = -16'sd25736;

  // one resampled particle as seen on the output channel
  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [HEAD_W-1:0]  heading;
    logic               last;
    logic               early;
  } pick_t;

  // tracks the stored particle set and the picks still owed by the block
  class pick_tracker;
    logic [SUM_W-1:0]  cum_weight [MAX_PARTS];
    logic [POS_W-1:0]  pose_x [MAX_PARTS];
    logic [POS_W-1:0]  pose_y [MAX_PARTS];
    logic [HEAD_W-1:0] pose_head [MAX_PARTS];
    logic [SUM_W-1:0]  prefix;
    logic [CNT_W-1:0]  count_reg;
    int unsigned       loaded;
    int unsigned       drawn;
    pick_t             picks_due [$];
    int unsigned       errors, n_loads, n_ignored, n_draws, n_early, n_wraps;

    function new();
      count_reg = COUNT_RESET;
      prefix    = '0;
      loaded    = 0;
      drawn     = 0;
      errors    = 0;
      n_loads   = 0;
      n_ignored = 0;
      n_draws   = 0;
      n_early   = 0;
      n_wraps   = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    // zero acts as one, anything past the memory size as the memory size
    function int unsigned active_count();
      int unsigned n;
      n = 32'(count_reg);
      if (n == 0) n = 1;
      if (n > MAX_PARTS) n = MAX_PARTS;
      return n;
    endfunction

    // bisection over the cumulative weights, ties resolved as the block does
    function int unsigned find_pick(logic [WEIGHT_W-1:0] r, int unsigned n);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = n - 1;
      if (r < cum_weight[0]) return 0;
      if (r > cum_weight[hi]) return hi;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (cum_weight[mid] < r) lo = mid;
        else hi = mid;
      end
      return hi;
    endfunction

    function void note_item(logic op, logic sos, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [HEAD_W-1:0] h, logic [WEIGHT_W-1:0] w,
                            logic [WEIGHT_W-1:0] r);
      int unsigned n, k;
      logic [SUM_W:0] total;
      pick_t p;
      n = active_count();
      if (op == OP_LOAD) begin
        if (sos) begin
          loaded = 0;
          prefix = '0;
          drawn  = 0;
        end
        if (loaded < n) begin
          total = {1'b0, prefix} + (SUM_W + 1)'(w);
          prefix = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
          cum_weight[loaded] = prefix;
          pose_x[loaded]     = x;
          pose_y[loaded]     = y;
          pose_head[loaded]  = h;
          loaded++;
          n_loads++;
        end else begin
          n_ignored++;
        end
        return;
      end
      n_draws++;
      p.index = '0;
      p.x = '0;
      p.y = '0;
      p.heading = '0;
      p.last = 1'b0;
      p.early = 1'b0;
      if (loaded < n) begin
        p.early = 1'b1;
        n_early++;
      end else begin
        k = find_pick(r, n);
        p.index   = k[INDEX_W-1:0];
        p.x       = pose_x[k];
        p.y       = pose_y[k];
        p.heading = pose_head[k];
        if (drawn + 1 >= n) begin
          p.last = 1'b1;
          drawn  = 0;
          n_wraps++;
        end else begin
          drawn++;
        end
      end
      picks_due.push_back(p);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_pick(pick_t got);
      pick_t want;
      if (picks_due.size() == 0) begin
        $error("result item arrived with none expected");
        errors++;
        return;
      end
      want = picks_due.pop_front();
      compare_field("picked_index", 32'(want.index), 32'(got.index));
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_heading", 32'(want.heading), 32'(got.heading));
      compare_field("last_of_set", 32'(want.last), 32'(got.last));
      compare_field("not_loaded", 32'(want.early), 32'(got.early));
    endfunction

    function int unsigned pending();
      return picks_due.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CNT_W-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = OP_LOAD;
  logic                       start_of_set_i = 1'b0;
  logic signed [POS_W-1:0]    pos_x_i = '0;
  logic signed [POS_W-1:0]    pos_y_i = '0;
  logic signed [HEAD_W-1:0]   heading_i = '0;
  logic [WEIGHT_W-1:0]        particle_weight_i = '0;
  logic [WEIGHT_W-1:0]        random_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [INDEX_W-1:0]         picked_index_o;
  logic signed [POS_W-1:0]    out_x_o;
  logic signed [POS_W-1:0]    out_y_o;
  logic signed [HEAD_W-1:0]   out_heading_o;
  logic                       last_of_set_o;
  logic                       not_loaded_o;

  pick_tracker tracker;
  int unsigned burst_left = 0;
  bit          quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned n_settings = 0;

  particle_multinomial_resampler #(
    .MAX_PARTICLES(MAX_PARTS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .start_of_set_i   (start_of_set_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .heading_i        (heading_i),
    .particle_weight_i(particle_weight_i),
    .random_value_i   (random_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .picked_index_o   (picked_index_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_heading_o    (out_heading_o),
    .last_of_set_o    (last_of_set_o),
    .not_loaded_o     (not_loaded_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // watch both channels and the register port
  always @(posedge clk_i) begin : watch
    pick_t got;
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_count(cfg_wdata_i);
      if (in_valid_i && in_ready_o) begin
        tracker.note_item(operation_i, start_of_set_i, pos_x_i, pos_y_i, heading_i,
                          particle_weight_i, random_value_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.index   = picked_index_o;
        got.x       = out_x_o;
        got.y       = out_y_o;
        got.heading = out_heading_o;
        got.last    = last_of_set_o;
        got.early   = not_loaded_o;
        tracker.check_pick(got);
      end
    end
  end

  // receiver back-pressure in modes: always ready, random, stall bursts, toggling
  initial begin : receiver
    int unsigned mode, span, stall_left;
    stall_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: begin
            if (stall_left != 0) begin
              stall_left--;
              out_ready_i <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(5, 40);
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
            end
          end
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  function automatic logic [HEAD_W-1:0] rand_heading();
    int v;
    v = int'($urandom_range(0, 51472)) - 25736;
    return v[HEAD_W-1:0];
  endfunction

  // weight shapes: spread to sum near one, sparse, any, or only the extremes
  function automatic logic [WEIGHT_W-1:0] rand_weight(int unsigned style, int unsigned n);
    int unsigned cap;
    cap = (2 * 65536) / n;
    if (cap > 65536) cap = 65536;
    case (style)
      0, 1, 2: return WEIGHT_W'($urandom_range(0, cap));
      3: return ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 65536)) : '0;
      4: return WEIGHT_W'($urandom_range(0, 65536));
      default: return $urandom_range(0, 1) ? WEIGHT_ONE : '0;
    endcase
  endfunction

  // draw values, often right on or just past a stored cumulative weight
  function automatic logic [WEIGHT_W-1:0] rand_value();
    int unsigned k;
    logic [SUM_W-1:0] c;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WEIGHT_ONE;
      2, 3: begin
        if (tracker.loaded != 0) begin
          k = $urandom_range(0, tracker.loaded - 1);
          c = tracker.cum_weight[k] + SUM_W'($urandom_range(0, 1));
          if (c <= WEIGHT_ONE) return c[WEIGHT_W-1:0];
        end
      end
      default: ;
    endcase
    return WEIGHT_W'($urandom_range(0, 65536));
  endfunction

  // present one item, with a random gap at the start of each burst
  task automatic send_item(input logic op, input logic sos, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [HEAD_W-1:0] h,
                           input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (quiet) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 20);
      else gap = $urandom_range(0, 4);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    start_of_set_i    <= sos;
    pos_x_i           <= x;
    pos_y_i           <= y;
    heading_i         <= h;
    particle_weight_i <= w;
    random_value_i    <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic load_one(input logic sos, input logic [WEIGHT_W-1:0] w);
    send_item(OP_LOAD, sos, $urandom, $urandom, rand_heading(), w,
              WEIGHT_W'($urandom_range(0, 65536)));
  endtask

  task automatic draw_one(input logic [WEIGHT_W-1:0] r);
    send_item(OP_DRAW, 1'($urandom_range(0, 1)), $urandom, $urandom, rand_heading(),
              WEIGHT_W'($urandom_range(0, 65536)), r);
  endtask

  // a fresh set of n particles, now and then an early draw slipped in
  task automatic load_set(input int unsigned n, input int unsigned style);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) draw_one(rand_value());
      load_one(i == 0, rand_weight(style, n));
    end
  endtask

  // hold off until every pick is back and the block has gone quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned n, v, m, style, k, base;
    bit reload;
    tracker = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // draws before a full set, at the reset count
    draw_one('0);
    send_item(OP_LOAD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, HEAD_MAX, WEIGHT_ONE, '0);
    draw_one(WEIGHT_ONE);

    // count of zero acts as one: every draw is last, extra load ignored
    drain();
    write_count(11'd0);
    draw_one(WEIGHT_ONE);
    send_item(OP_LOAD, 1'b0, 32'h0, 32'h0, 16'h0, WEIGHT_ONE, '0);
    draw_one('0);

    // four particles with tied and extreme cumulative weights
    drain();
    write_count(11'd4);
    draw_one(17'd5);
    send_item(OP_LOAD, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, HEAD_MIN, '0, WEIGHT_ONE);
    send_item(OP_LOAD, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, '0, '0);
    send_item(OP_LOAD, 1'b0, 32'h0, 32'hFFFF_FFFF, HEAD_MAX, WEIGHT_ONE, '0);
    send_item(OP_LOAD, 1'b0, 32'h1234_5678, 32'h8765_4321, 16'h0, 17'd1, '0);
    draw_one('0);
    draw_one(17'd1);
    draw_one(WEIGHT_ONE);

    // count lowered below the draws already made: next draw wraps
    drain();
    write_count(11'd2);
    draw_one(WEIGHT_ONE);
    draw_one('0);
    drain();
    write_count(11'd1);
    draw_one(17'd12345);

    // count past the memory size acts as the memory size
    drain();
    write_count(11'd2047);
    draw_one(WEIGHT_ONE);

    // one full-size set for the deepest search
    drain();
    write_count(11'd1024);
    n = tracker.active_count();
    load_set(n, 0);
    repeat (48) draw_one(rand_value());

    // random phases, mostly small sets
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: v = 0;
        1: v = $urandom_range(1025, 2047);
        2, 3, 4: v = $urandom_range(33, 100);
        5, 6, 7, 8, 9: v = $urandom_range(9, 32);
        default: v = $urandom_range(1, 8);
      endcase
      reload = (v <= MAX_PARTS) && ($urandom_range(0, 3) != 0);
      quiet  = ($urandom_range(0, 4) == 0);
      style  = $urandom_range(0, 5);
      drain();
      write_count(v[CNT_W-1:0]);
      n = tracker.active_count();
      if (reload) begin
        load_set(n, style);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) load_one(1'b0, rand_weight(style, n));
        end
      end
      m = $urandom_range(1, 2 * n + 2);
      if (m > 80) m = 80;
      repeat (m) begin
        k = $urandom_range(0, 59);
        if (k == 0) load_one(1'b1, rand_weight(style, n));
        else if (k == 1) drain();
        draw_one(rand_value());
      end
    end

    drain();
    $display("covered %0d loads (%0d ignored past the count), %0d draws", tracker.n_loads,
             tracker.n_ignored, tracker.n_draws);
    $display("%0d draws before a full set, %0d set wraps, %0d count settings",
             tracker.n_early, tracker.n_wraps, n_settings);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pmr_pkg.sv
rtl/pmr_ram.sv
rtl/pmr_search.sv
rtl/particle_multinomial_resampler.sv
verif/tb_top.sv
